>>> rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// shared types and constants of the running median unit
// ----------------------------------------------------------------------------
package swrm_pkg;

   localparam int WINDOW_MAX_DEFAULT  = 32;
   localparam int SAMPLE_BITS_DEFAULT = 8;
   localparam int LEN_BITS            = 6;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd9;

   // controller to datapath
   typedef struct packed {
      logic start;      // latch the new transaction
      logic scan_step;  // count one ring entry against the target
      logic seek_high;  // rank target is the upper middle
      logic load_low;   // capture lower middle value
      logic load_high;  // capture upper middle value
      logic rsp_load;   // load the result register
   } swrm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;  // last entry of the current pass
      logic found;      // current candidate reached the rank
      logic even;       // held count is even
   } swrm_status_type;

endpackage

>>> rtl/swrm_if.sv
// ----------------------------------------------------------------------------
// swrm_if
// valid/ready channel carrying a payload of generic width
// ----------------------------------------------------------------------------
interface swrm_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/swrm_datapath.sv
// ----------------------------------------------------------------------------
// swrm_datapath
// ring memory, fill bookkeeping and rank search by counting
// ----------------------------------------------------------------------------
module swrm_datapath import swrm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swrm_cmd_type           cmd,
   output swrm_status_type        status,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_restart,
   input  logic [LEN_BITS-1:0]    window_length,
   output logic [SAMPLE_BITS-1:0] rsp_median,
   output logic [LEN_BITS-1:0]    rsp_held_count
);
   localparam int SLOT_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int VAL_BITS  = SAMPLE_BITS + 1;

   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   logic [SLOT_BITS-1:0] write_slot_ff, write_slot_in;
   logic [CNT_BITS-1:0]  fill_count_ff, fill_count_in;
   logic [CNT_BITS-1:0]  eff_len;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic                 rd_valid_ff;
   logic [VAL_BITS-1:0]  cand_ff, cand_in;
   logic [CNT_BITS-1:0]  le_ff, le_in;
   logic [SAMPLE_BITS-1:0] low_ff, high_ff;
   logic [SLOT_BITS-1:0] base_ff;
   logic [CNT_BITS-1:0]  rank_lo, rank_hi;
   logic [SAMPLE_BITS-1:0] med_ff;
   logic [LEN_BITS-1:0]  cnt_out_ff;
   logic [CNT_BITS:0]    fill_plus;
   logic [SAMPLE_BITS:0] mid_sum;
   logic [SLOT_BITS-1:0] rd_addr;
   logic [SLOT_BITS:0]   addr_wide;
   logic                 pass_last;
   logic [CNT_BITS-1:0]  le_next;

   // effective window length: zero counts as one, saturate at the ring depth
   always_comb begin
      if (window_length == '0) begin
         eff_len = CNT_BITS'(1);
      end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
         eff_len = CNT_BITS'(WINDOW_MAX);
      end else begin
         eff_len = CNT_BITS'(window_length);
      end
   end

   always_comb begin
      fill_plus     = (req_restart ? '0 : {1'b0, fill_count_ff}) + 1'b1;
      fill_count_in = fill_count_ff;
      write_slot_in = write_slot_ff;
      if (cmd.start) begin
         fill_count_in = (fill_plus > {1'b0, eff_len}) ? eff_len
                                                        : fill_plus[CNT_BITS-1:0];
         if (req_restart) begin
            write_slot_in = SLOT_BITS'(1 % WINDOW_MAX);
         end else if (32'(write_slot_ff) == WINDOW_MAX - 1) begin
            write_slot_in = '0;
         end else begin
            write_slot_in = write_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         fill_count_ff <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         fill_count_ff <= fill_count_in;
      end
   end

   // ring base is the oldest held slot; the read follows the next index
   assign addr_wide = {1'b0, base_ff} + (SLOT_BITS+1)'(idx_in);
   assign rd_addr   = (32'(addr_wide) >= WINDOW_MAX)
                    ? SLOT_BITS'(32'(addr_wide) - WINDOW_MAX) : addr_wide[SLOT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ring_mem[req_restart ? '0 : write_slot_ff] <= req_sample;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   assign rank_hi = fill_count_ff >> 1;
   assign rank_lo = fill_count_ff[0] ? rank_hi : rank_hi - 1'b1;
   assign pass_last = (idx_ff == fill_count_ff - 1'b1);
   assign le_next = le_ff + ((rd_valid_ff && {1'b0, rd_data_ff} <= cand_ff) ? 1'b1 : 1'b0);

   // search value v: count entries <= v; smallest v with count > rank is the answer
   always_comb begin
      idx_in  = idx_ff;
      cand_in = cand_ff;
      le_in   = le_ff;
      if (cmd.start) begin
         idx_in  = '0;
         cand_in = '0;
         le_in   = '0;
      end else if (cmd.scan_step) begin
         if (rd_valid_ff && pass_last) begin
            idx_in = '0;
            le_in  = '0;
            if (!status.found) begin
               cand_in = cand_ff + 1'b1;
            end
         end else if (!rd_valid_ff) begin
            idx_in = idx_ff;
         end else begin
            idx_in = idx_ff + 1'b1;
            le_in  = le_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_step && !(rd_valid_ff && pass_last) && !cmd.start;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cand_ff <= cand_in;
      le_ff   <= le_in;
      if (cmd.start) begin
         base_ff <= req_restart ? '0
                  : ((32'(write_slot_ff) + WINDOW_MAX + 1 - 32'(fill_count_in)) >= WINDOW_MAX)
                  ? SLOT_BITS'(32'(write_slot_ff) + 1 - 32'(fill_count_in))
                  : SLOT_BITS'(32'(write_slot_ff) + WINDOW_MAX + 1 - 32'(fill_count_in));
      end
      if (cmd.load_low) begin
         low_ff <= cand_ff[SAMPLE_BITS-1:0];
      end
      if (cmd.load_high) begin
         high_ff <= cand_ff[SAMPLE_BITS-1:0];
      end
   end

   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         med_ff     <= mid_sum[SAMPLE_BITS:1];
         cnt_out_ff <= LEN_BITS'(fill_count_ff);
      end
   end

   // the pass ends on the last entry; found compares the final count with the rank
   always_comb begin
      status.scan_last = rd_valid_ff && pass_last;
      status.even      = !fill_count_ff[0];
      status.found     = le_next > ((cmd.seek_high || !status.even) ? rank_hi : rank_lo);
   end

   assign rsp_median     = med_ff;
   assign rsp_held_count = cnt_out_ff;
endmodule

>>> rtl/swrm_controller.sv
// ----------------------------------------------------------------------------
// swrm_controller
// sequences the rank passes for one transaction
// ----------------------------------------------------------------------------
module swrm_controller import swrm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  swrm_status_type status,
   output swrm_cmd_type    cmd
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOW  = 4'b0010,
      ST_HIGH = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      start;

   assign start     = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.start    = start;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOW;
            end
         end
         ST_LOW: begin
            cmd.scan_step = 1'b1;
            cmd.load_low  = status.scan_last && status.found;
            if (cmd.load_low) begin
               state_in = ST_HIGH;
            end
         end
         ST_HIGH: begin
            cmd.scan_step = 1'b1;
            cmd.seek_high = 1'b1;
            cmd.load_high = status.scan_last && status.found;
            if (cmd.load_high) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

>>> rtl/sliding_window_running_median_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_running_median_unit
// running median over the last window_length samples
// ----------------------------------------------------------------------------
// Each transaction writes one sample into a ring and returns the median of
// the held samples (floored mean of the two middles for an even count) and
// the held count. The median is found by a value search: for each candidate
// value one pass counts the held entries not above it, through one ring read
// port. The lower middle is searched from zero, then the search goes on from
// there for the upper middle. The next sample is accepted once the result
// has been taken.
module sliding_window_running_median_unit import swrm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_median,
   output logic [LEN_BITS-1:0]    rsp_held_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LEN_BITS-1:0]    csr_data
);
   swrm_if #(.WIDTH(SAMPLE_BITS + 1)) req_ch ();
   swrm_if #(.WIDTH(LEN_BITS))        csr_ch ();

   swrm_cmd_type          cmd;
   swrm_status_type       status;
   logic [LEN_BITS-1:0]   window_length_ff;

   assign req_ch.valid = req_valid;
   assign req_ch.data  = {req_restart, req_sample};
   assign req_ready    = req_ch.ready;
   assign csr_ch.valid = csr_valid;
   assign csr_ch.data  = csr_data;
   assign csr_ch.ready = 1'b1;
   assign csr_ready    = csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= LEN_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         window_length_ff <= csr_ch.data;
      end
   end

   swrm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swrm_datapath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_ch.data[SAMPLE_BITS-1:0]),
      .req_restart    (req_ch.data[SAMPLE_BITS]),
      .window_length  (window_length_ff),
      .rsp_median     (rsp_median),
      .rsp_held_count (rsp_held_count)
   );

`ifndef SYNTH
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("transaction accepted while busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_held_count != '0))
      else $error("held count zero on result");

   a_one_hot_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.load_low, cmd.load_high, cmd.rsp_load}))
      else $error("conflicting datapath commands");
`endif

endmodule

>>> tb/tb_sliding_window_running_median_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_running_median_unit
// self-checking bench for the sliding window running median unit
// ----------------------------------------------------------------------------
// Directed samples at the value extremes, restarts and even counts, then
// random phases over several window lengths (zero, saturating, both ends).
// A ring model predicts median and held count for every accepted sample;
// results are checked in order under random source and sink idling, off in the last phase.
// ----------------------------------------------------------------------------
module tb_sliding_window_running_median_unit;
   import swrm_pkg::*;

   typedef struct {
      logic [7:0] sample;
      logic       restart;
   } pixel_item_type;

   typedef struct {
      logic [7:0]          median;
      logic [LEN_BITS-1:0] held;
   } median_result_type;

   logic clock;
   logic reset;

   swrm_if #(.WIDTH(9))            req_if ();
   swrm_if #(.WIDTH(8 + LEN_BITS)) rsp_if ();
   swrm_if #(.WIDTH(LEN_BITS))     csr_if ();

   pixel_item_type    pixel_queue[$];
   median_result_type median_queue[$];

   logic [7:0]          ring_model[32];
   logic [4:0]          slot_model;
   logic [LEN_BITS-1:0] fill_model;
   logic [LEN_BITS-1:0] length_model;

   int errors;
   int issued;
   int accepted;
   int checked;
   int restarts;
   int req_gap;
   int rsp_gap;
   bit quiet;

   sliding_window_running_median_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_sample     (req_if.data[7:0]),
      .req_restart    (req_if.data[8]),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_median     (rsp_if.data[7+LEN_BITS:LEN_BITS]),
      .rsp_held_count (rsp_if.data[LEN_BITS-1:0]),
      .csr_valid      (csr_if.valid),
      .csr_ready      (csr_if.ready),
      .csr_data       (csr_if.data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, checked, got, want);
      errors++;
   endtask

   task automatic predict_median(input pixel_item_type it);
      logic [7:0]          win[32];
      logic [7:0]          key;
      logic [LEN_BITS-1:0] eff;
      logic [LEN_BITS-1:0] cnt;
      logic [8:0]          sum;
      median_result_type   res;
      int                  j;
      eff = length_model;
      if (eff == 0) eff = 1;
      if (eff > 32) eff = 32;
      if (it.restart) begin
         fill_model = 0;
         slot_model = 0;
      end
      ring_model[slot_model] = it.sample;
      slot_model = slot_model + 5'd1;
      cnt = fill_model + 1;
      if (cnt > eff) cnt = eff;
      fill_model = cnt;
      for (int i = 0; i < cnt; i++) win[i] = ring_model[5'(slot_model - 5'd1 - 5'(i))];
      for (int i = 1; i < cnt; i++) begin
         key = win[i];
         j = i;
         while (j > 0 && win[j-1] > key) begin
            win[j] = win[j-1];
            j--;
         end
         win[j] = key;
      end
      if (cnt[0]) begin
         res.median = win[cnt/2];
      end else begin
         sum = win[cnt/2-1] + win[cnt/2];
         res.median = sum[8:1];
      end
      res.held = cnt;
      median_queue.push_back(res);
   endtask

   // sampling side: predictor on accepted inputs, checker on accepted results
   always @(posedge clock) begin
      median_result_type want;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) length_model = csr_if.data;
         if (req_if.valid && req_if.ready) begin
            predict_median('{sample: req_if.data[7:0], restart: req_if.data[8]});
            accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (median_queue.size() == 0) begin
               $display("unexpected result transaction, median %0d",
                        rsp_if.data[7+LEN_BITS:LEN_BITS]);
               errors++;
            end else begin
               want = median_queue.pop_front();
               if (rsp_if.data[7+LEN_BITS:LEN_BITS] !== want.median)
                  report("median", rsp_if.data[7+LEN_BITS:LEN_BITS], want.median);
               if (rsp_if.data[LEN_BITS-1:0] !== want.held)
                  report("held_count", rsp_if.data[LEN_BITS-1:0], want.held);
            end
            checked++;
         end
      end
   end

   // input driver
   always @(negedge clock) begin
      pixel_item_type it;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && accepted < issued)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            req_gap = $urandom_range(0, 8);
            req_if.valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            it = pixel_queue.pop_front();
            req_if.data  <= {it.restart, it.sample};
            req_if.valid <= 1'b1;
            issued++;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result sink with stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_gap = $urandom_range(0, 8);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic push_pixel(input logic [7:0] s, input logic r);
      pixel_queue.push_back('{sample: s, restart: r});
      if (r) restarts++;
   endtask

   function automatic logic [7:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 8'($urandom_range(0, 31));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic drain();
      while (pixel_queue.size() > 0 || accepted < issued || median_queue.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_BITS-1:0] v);
      @(negedge clock);
      csr_if.data  <= v;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   logic [LEN_BITS-1:0] lengths[8] = '{6'd0, 6'd63, 6'd32, 6'd1, 6'd2, 6'd33, 6'd0, 6'd5};

   initial begin
      errors   = 0;
      issued   = 0;
      accepted = 0;
      checked  = 0;
      restarts = 0;
      req_gap  = 0;
      rsp_gap  = 0;
      quiet    = 1'b0;
      slot_model   = 0;
      fill_model   = 0;
      length_model = LEN_RESET;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, even-count means, restarts, default length
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd254, 1'b0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b1);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd170, 1'b1);
      push_pixel(8'd85, 1'b0);
      for (int i = 0; i < 10; i++) push_pixel(8'(i * 3), 1'b0);
      push_pixel(8'd1, 1'b1);
      push_pixel(8'd3, 1'b0);
      drain();

      // random phases over window lengths, length changes keep held samples
      for (int p = 0; p < 8; p++) begin
         if (p == 6) lengths[p] = LEN_BITS'($urandom_range(0, 63));
         if (p == 7) quiet = 1'b1;
         write_length(lengths[p]);
         for (int i = 0; i < 54; i++)
            push_pixel(pick_sample(), $urandom_range(0, 24) == 0);
         drain();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d samples, %0d restarts, %0d results checked",
               accepted, restarts, checked);
      $display("window lengths: reset default, zero, above max, 1, 2, 32 and random");
      if (errors == 0 && median_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
